// ===== src/pse_pkg.sv =====
`timescale 1ns / 1ps

package pse_pkg;

    localparam int DATA_W = 32;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;

    typedef struct packed {
        logic [7:0] char_code;
        logic       is_final;
    } cmd_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     divide_error;
    } res_t;

endpackage

// ===== src/pse_ram.sv =====
`timescale 1ns / 1ps

module pse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/pse_div.sv =====
`timescale 1ns / 1ps

module pse_div
    import pse_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DATA_W-1:0] dividend,
    input  logic [DATA_W-1:0] divisor,
    output logic              done,
    output logic [DATA_W-1:0] quotient
);

    localparam int CW = $clog2(DATA_W);

    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] dsr_reg, dsr_next;
    logic              neg_reg, neg_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DATA_W:0]   trial;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[DATA_W-1]} - {1'b0, dsr_reg};
        if (start)
        begin
            // Work on magnitudes; the sign is restored at the output.
            rem_next  = '0;
            quo_next  = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
            dsr_next  = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
            neg_next  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[DATA_W])
            begin
                rem_next = trial[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[DATA_W-2:0], quo_reg[DATA_W-1]};
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(DATA_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

endmodule

// ===== src/postfix_stack_evaluator_core.sv =====
`timescale 1ns / 1ps

// Postfix evaluator: one character per request, digits push 0-9, + - * / pop two operands
// and push the 32-bit result, any other character pops and discards two operands. The
// request marked final returns the top of stack (0 if empty) with a sticky divide-by-zero
// flag and empties the stack. Operands live in a single-port-read stack RAM with a registered
// read, so every pop is a read followed by a wait: a digit is written straight from idle,
// + - * and unknown characters pop two operands and execute (+ - * then push), and / with a
// nonzero divisor also waits on the bit-per-cycle divider. A final request then reads the
// top of stack. A result waiting in the output register does not block new requests until the next final one.
module postfix_stack_evaluator_core
    import pse_pkg::*;
#(
    parameter int STACK_DEPTH = 128
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd,
    output logic res_valid,
    input  logic res_stall,
    output res_t res
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam logic [DW-1:0] DEPTH_FULL = DW'(STACK_DEPTH);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_POP_R   = 3'd1;
    localparam logic [2:0] S_POP_L   = 3'd2;
    localparam logic [2:0] S_EXEC    = 3'd3;
    localparam logic [2:0] S_DIV     = 3'd4;
    localparam logic [2:0] S_PUSH    = 3'd5;
    localparam logic [2:0] S_FIN_RD  = 3'd6;
    localparam logic [2:0] S_FIN_OUT = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [DW-1:0]     depth_reg, depth_next;
    logic              err_reg, err_next;
    logic [7:0]        char_reg, char_next;
    logic              fin_reg, fin_next;
    logic              hit_reg, hit_next;
    logic [DATA_W-1:0] right_reg, right_next;
    logic [DATA_W-1:0] result_reg, result_next;
    logic              res_valid_reg, res_valid_next;
    res_t              res_reg, res_next;

    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [DATA_W-1:0] ram_wdata, ram_rdata;
    logic [DW-1:0]     depth_m1;
    logic [DATA_W-1:0] popped;
    logic [3:0]        digit;
    logic              div_start, div_done;
    logic [DATA_W-1:0] div_quotient;

    pse_ram #(
        .WIDTH(DATA_W),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    pse_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(popped),
        .divisor (right_reg),
        .done    (div_done),
        .quotient(div_quotient)
    );

    assign depth_m1  = depth_reg - 1'b1;
    assign ram_raddr = depth_m1[AW-1:0];
    assign ram_waddr = depth_reg[AW-1:0];
    assign digit     = 4'(cmd.char_code - CHAR_ZERO);
    // An operand read from an empty stack comes back as zero.
    assign popped    = hit_reg ? ram_rdata : '0;
    assign cmd_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        depth_next     = depth_reg;
        err_next       = err_reg;
        char_next      = char_reg;
        fin_next       = fin_reg;
        hit_next       = hit_reg;
        right_next     = right_reg;
        result_next    = result_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && res_stall;
        ram_we         = 1'b0;
        ram_wdata      = result_reg;
        ram_re         = 1'b0;
        div_start      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    char_next = cmd.char_code;
                    fin_next  = cmd.is_final;
                    if (cmd.char_code >= CHAR_ZERO && cmd.char_code <= CHAR_NINE)
                    begin
                        if (depth_reg != DEPTH_FULL)
                        begin
                            ram_we     = 1'b1;
                            ram_wdata  = {{(DATA_W-4){1'b0}}, digit};
                            depth_next = depth_reg + 1'b1;
                        end
                        state_next = cmd.is_final ? S_FIN_RD : S_IDLE;
                    end
                    else
                    begin
                        state_next = S_POP_R;
                    end
                end
            end
            S_POP_R:
            begin
                hit_next = (depth_reg != '0);
                if (depth_reg != '0)
                begin
                    ram_re     = 1'b1;
                    depth_next = depth_m1;
                end
                state_next = S_POP_L;
            end
            S_POP_L:
            begin
                right_next = popped;
                hit_next   = (depth_reg != '0);
                if (depth_reg != '0)
                begin
                    ram_re     = 1'b1;
                    depth_next = depth_m1;
                end
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_PUSH;
                if (char_reg == CHAR_PLUS)
                begin
                    result_next = popped + right_reg;
                end
                else if (char_reg == CHAR_MINUS)
                begin
                    result_next = popped - right_reg;
                end
                else if (char_reg == CHAR_STAR)
                begin
                    result_next = popped * right_reg;
                end
                else if (char_reg == CHAR_SLASH)
                begin
                    if (right_reg == '0)
                    begin
                        result_next = '0;
                        err_next    = 1'b1;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                end
                else
                begin
                    state_next = fin_reg ? S_FIN_RD : S_IDLE;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    result_next = div_quotient;
                    state_next  = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (depth_reg != DEPTH_FULL)
                begin
                    ram_we     = 1'b1;
                    depth_next = depth_reg + 1'b1;
                end
                state_next = fin_reg ? S_FIN_RD : S_IDLE;
            end
            S_FIN_RD:
            begin
                hit_next = (depth_reg != '0);
                ram_re   = (depth_reg != '0);
                state_next = S_FIN_OUT;
            end
            S_FIN_OUT:
            begin
                // Read data stays put until the output register frees up.
                if (!res_valid_reg || !res_stall)
                begin
                    res_next.value        = popped;
                    res_next.divide_error = err_reg;
                    res_valid_next        = 1'b1;
                    depth_next            = '0;
                    err_next              = 1'b0;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            depth_reg     <= '0;
            err_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            err_reg       <= err_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg   <= char_next;
        fin_reg    <= fin_next;
        hit_reg    <= hit_next;
        right_reg  <= right_next;
        result_reg <= result_next;
        res_reg    <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== verif/postfix_result_checker.sv =====
`timescale 1ns / 1ps

module postfix_result_checker
    import pse_pkg::*;
#(
    parameter int STACK_DEPTH = 128
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    input  logic cmd_stall,
    input  cmd_t cmd,
    input  logic res_valid,
    input  logic res_stall,
    input  res_t res,
    output int   fail_count,
    output int   pending
);

    logic [DATA_W-1:0] operand_mem [STACK_DEPTH];
    int                stack_depth;
    logic              div_err_seen;
    res_t              expected_results [$];

    // Signed division truncating toward zero, done on magnitudes so that the
    // most negative value divided by minus one wraps instead of overflowing.
    function automatic logic [DATA_W-1:0] trunc_div(input logic [DATA_W-1:0] num,
                                                    input logic [DATA_W-1:0] den);
        logic [DATA_W-1:0] num_mag;
        logic [DATA_W-1:0] den_mag;
        logic [DATA_W-1:0] quot;
        num_mag = num[DATA_W-1] ? (0 - num) : num;
        den_mag = den[DATA_W-1] ? (0 - den) : den;
        quot = num_mag / den_mag;
        return (num[DATA_W-1] != den[DATA_W-1]) ? (0 - quot) : quot;
    endfunction

    task automatic push_operand(input logic [DATA_W-1:0] v);
        if (stack_depth < STACK_DEPTH)
        begin
            operand_mem[stack_depth] = v;
            stack_depth++;
        end
    endtask

    task automatic pop_operand(output logic [DATA_W-1:0] v);
        if (stack_depth == 0)
        begin
            v = '0;
        end
        else
        begin
            stack_depth--;
            v = operand_mem[stack_depth];
        end
    endtask

    task automatic eval_char(input cmd_t c);
        logic [DATA_W-1:0] rhs;
        logic [DATA_W-1:0] lhs;
        logic [DATA_W-1:0] top;
        res_t              r;
        if (c.char_code >= CHAR_ZERO && c.char_code <= CHAR_NINE)
        begin
            push_operand(DATA_W'(c.char_code - CHAR_ZERO));
        end
        else
        begin
            pop_operand(rhs);
            pop_operand(lhs);
            case (c.char_code)
                CHAR_PLUS:  push_operand(lhs + rhs);
                CHAR_MINUS: push_operand(lhs - rhs);
                CHAR_STAR:  push_operand(lhs * rhs);
                CHAR_SLASH:
                begin
                    if (rhs == '0)
                    begin
                        div_err_seen = 1'b1;
                        push_operand('0);
                    end
                    else
                    begin
                        push_operand(trunc_div(lhs, rhs));
                    end
                end
                default: ;
            endcase
        end
        if (c.is_final)
        begin
            pop_operand(top);
            r.value = top;
            r.divide_error = div_err_seen;
            expected_results.push_back(r);
            stack_depth = 0;
            div_err_seen = 1'b0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            stack_depth = 0;
            div_err_seen = 1'b0;
            expected_results.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            // A result can never belong to a request taken at the same edge,
            // so results are checked before the new request is evaluated.
            if (res_valid && !res_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result value %0d divide_error %0b",
                             $time, res.value, res.divide_error);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (res.value !== want.value)
                    begin
                        $display("%0t: value expected %0d actual %0d",
                                 $time, want.value, res.value);
                        fail_count++;
                    end
                    if (res.divide_error !== want.divide_error)
                    begin
                        $display("%0t: divide_error expected %0b actual %0b",
                                 $time, want.divide_error, res.divide_error);
                        fail_count++;
                    end
                end
            end
            if (cmd_valid && !cmd_stall)
                eval_char(cmd);
            pending = expected_results.size();
        end
    end

endmodule

// ===== verif/tb_postfix_stack_evaluator_core.sv =====
`timescale 1ns / 1ps

module tb_postfix_stack_evaluator_core;
    import pse_pkg::*;

    localparam int STACK_DEPTH  = 128;
    localparam int ITEM_TARGET  = 1150;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 100;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cmd_valid = 1'b0;
    cmd_t cmd       = '0;
    logic res_stall = 1'b0;
    logic cmd_stall;
    logic res_valid;
    res_t res;

    int   fail_count;
    int   pending;
    int   cycle_count = 0;
    int   n_items     = 0;
    bit   steady_in   = 1'b0;
    logic [7:0] expr_q [$];

    always #1 clk = ~clk;

    postfix_stack_evaluator_core #(
        .STACK_DEPTH(STACK_DEPTH)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd(cmd),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res(res)
    );

    postfix_result_checker #(
        .STACK_DEPTH(STACK_DEPTH)
    ) i_checker (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd(cmd),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res(res),
        .fail_count(fail_count),
        .pending(pending)
    );

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Output back-pressure in runs: mostly short stalls, a few long ones and
    // now and then a long stretch with no stall at all.
    always @(posedge clk)
    begin : out_stall_gen
        int   pick;
        int   run_left;
        logic stall_now;
        if (run_left <= 0)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                stall_now = 1'b0;
                run_left = $urandom_range(1, 6);
            end
            else if (pick < 88)
            begin
                stall_now = 1'b1;
                run_left = $urandom_range(1, 3);
            end
            else if (pick < 95)
            begin
                stall_now = 1'b1;
                run_left = $urandom_range(10, 60);
            end
            else
            begin
                stall_now = 1'b0;
                run_left = $urandom_range(50, 200);
            end
        end
        res_stall <= stall_now;
        run_left--;
    end

    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (steady_in || pick < 60)
            return 0;
        else if (pick < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    task automatic send_char(input logic [7:0] ch, input logic fin);
        int gap;
        cmd <= '{char_code: ch, is_final: fin};
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        n_items++;
        gap = pick_gap();
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_expr();
        foreach (expr_q[i])
            send_char(expr_q[i], i == expr_q.size() - 1);
        expr_q.delete();
    endtask

    function automatic logic [7:0] rand_digit();
        if ($urandom_range(0, 4) == 0)
            return CHAR_ZERO;
        return CHAR_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_op();
        case ($urandom_range(0, 3))
            0: return CHAR_PLUS;
            1: return CHAR_MINUS;
            2: return CHAR_STAR;
            default: return CHAR_SLASH;
        endcase
    endfunction

    // Random well-formed postfix expression with the given number of operators.
    task automatic gen_wellformed(input int n_ops);
        int pushes_left;
        int ops_left;
        int live;
        pushes_left = n_ops + 1;
        ops_left = n_ops;
        live = 0;
        while (pushes_left > 0 || ops_left > 0)
        begin
            if (pushes_left > 0 && (live < 2 || $urandom_range(0, 1) == 1))
            begin
                expr_q.push_back(rand_digit());
                pushes_left--;
                live++;
            end
            else
            begin
                expr_q.push_back(rand_op());
                ops_left--;
                live--;
            end
        end
    endtask

    // Builds the most negative value as 8^10 * 2, then divides it.
    task automatic gen_min_divide();
        expr_q.push_back(CHAR_ZERO + 8'd8);
        repeat (9)
        begin
            expr_q.push_back(CHAR_ZERO + 8'd8);
            expr_q.push_back(CHAR_STAR);
        end
        expr_q.push_back(CHAR_ZERO + 8'd2);
        expr_q.push_back(CHAR_STAR);
        case ($urandom_range(0, 2))
            0:
            begin
                expr_q.push_back(CHAR_ZERO);
                expr_q.push_back(CHAR_ZERO + 8'd1);
                expr_q.push_back(CHAR_MINUS);
            end
            1: expr_q.push_back(CHAR_ZERO + 8'd1);
            default: expr_q.push_back(CHAR_ZERO + 8'd7);
        endcase
        expr_q.push_back(CHAR_SLASH);
    endtask

    // Chains of mostly multiplications that push values past 32 bits.
    task automatic gen_overflow();
        expr_q.push_back(CHAR_ZERO + 8'($urandom_range(2, 9)));
        repeat ($urandom_range(8, 20))
        begin
            expr_q.push_back(CHAR_ZERO + 8'($urandom_range(1, 9)));
            expr_q.push_back(($urandom_range(0, 9) < 6) ? CHAR_STAR : rand_op());
        end
    endtask

    // Runs the stack to near or past full, then folds some of it back.
    task automatic gen_fill();
        repeat ($urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 8))
            expr_q.push_back(rand_digit());
        repeat ($urandom_range(1, 10))
            expr_q.push_back(($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255))
                                                          : rand_op());
    endtask

    task automatic gen_noise();
        repeat ($urandom_range(1, 12))
            expr_q.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic gen_broken();
        gen_wellformed($urandom_range(1, 6));
        repeat ($urandom_range(1, 2))
            expr_q[$urandom_range(0, expr_q.size() - 1)] = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 2) == 0)
            expr_q.push_front(rand_op());
    endtask

    initial
    begin
        int pick;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Operator on an empty stack.
        expr_q = '{CHAR_PLUS};
        send_expr();
        // Division by zero.
        expr_q = '{CHAR_ZERO + 8'd9, CHAR_ZERO, CHAR_SLASH};
        send_expr();
        // Negative quotient truncates toward zero: -3 / 2.
        expr_q = '{CHAR_ZERO, CHAR_ZERO + 8'd3, CHAR_MINUS, CHAR_ZERO + 8'd2, CHAR_SLASH};
        send_expr();
        // Unknown characters at both ends of the code range discard operands.
        expr_q = '{CHAR_ZERO + 8'd5, CHAR_ZERO + 8'd6, 8'hFF};
        send_expr();
        expr_q = '{CHAR_ZERO + 8'd7, 8'h00};
        send_expr();
        expr_q = '{CHAR_ZERO + 8'd9, CHAR_NINE, CHAR_STAR};
        send_expr();
        expr_q = '{CHAR_ZERO + 8'd1};
        send_expr();

        while (n_items < ITEM_TARGET)
        begin
            steady_in = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 55)
                gen_wellformed(($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                            : $urandom_range(0, 8));
            else if (pick < 60)
                gen_min_divide();
            else if (pick < 65)
                gen_overflow();
            else if (pick < 67)
                gen_fill();
            else if (pick < 82)
                gen_noise();
            else
                gen_broken();
            send_expr();
        end

        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
